// ----- rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache table.
// Holds entry sizing, transaction payload structs and operation codes.
// No dependencies; used by lfu_cache_table and the testbench.
package lfu_pkg;

  // Table sizing
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int RANK_W     = IDX_W;
  localparam int CAP_W      = 5;
  localparam int WORD_W     = 32;

  // Operation codes
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  // Request transaction
  typedef struct packed {
    func_t                    func;
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] value;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] read_value;
    logic                     evicted;
    logic signed [WORD_W-1:0] evicted_key;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

endpackage

// ----- rtl/lfu_cache_table.sv -----
// LFU cache table with LRU tie break: serial scan sequencer and entry storage.
// Depends on lfu_pkg for sizing, payload structs and codes.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | in_data  (lfu_pkg::req_t)
//   out     | output    | out_valid / out_stall| out_data (lfu_pkg::rsp_t)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (capacity, 5 bits)
//
// A transaction is a one-entry-per-cycle scan of the table for key match,
// victim and free slot, then the update cycle.
// in_stall is high from acceptance until the update cycle has finished.
// The update cycle waits while the output register still holds an untaken
// result; a finished result otherwise waits there without blocking input.
// Synchronous reset empties the table and sets capacity to ENTRIES.
module lfu_cache_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lfu_pkg::req_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lfu_pkg::rsp_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]        cfg_data
);

  localparam logic [lfu_pkg::IDX_W-1:0] LAST_IDX = lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1);
  localparam logic [lfu_pkg::COUNT_BITS-1:0] COUNT_MAX = {lfu_pkg::COUNT_BITS{1'b1}};

  // Entry storage
  logic [lfu_pkg::ENTRIES-1:0]       valid;
  logic [lfu_pkg::WORD_W-1:0]        key_mem   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::WORD_W-1:0]        data_mem  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::COUNT_BITS-1:0]    count_mem [lfu_pkg::ENTRIES];
  logic [lfu_pkg::RANK_W-1:0]        rank_mem  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::OCC_W-1:0]         occ;
  logic [lfu_pkg::CAP_W-1:0]         capacity;

  // Sequencer and current request
  lfu_pkg::state_t                   state;
  logic [lfu_pkg::IDX_W-1:0]         idx;
  lfu_pkg::req_t                     req;

  // Scan results
  logic                              hit_found;
  logic [lfu_pkg::IDX_W-1:0]         hit_idx;
  logic [lfu_pkg::WORD_W-1:0]        hit_data;
  logic [lfu_pkg::RANK_W-1:0]        hit_rank;
  logic                              vic_have;
  logic [lfu_pkg::IDX_W-1:0]         vic_idx;
  logic [lfu_pkg::WORD_W-1:0]        vic_key;
  logic [lfu_pkg::COUNT_BITS-1:0]    vic_count;
  logic [lfu_pkg::RANK_W-1:0]        vic_rank;
  logic                              free_have;
  logic [lfu_pkg::IDX_W-1:0]         free_idx;

  // Scan element at idx
  logic                              s_valid;
  logic [lfu_pkg::WORD_W-1:0]        s_key;
  logic [lfu_pkg::COUNT_BITS-1:0]    s_count;
  logic [lfu_pkg::RANK_W-1:0]        s_rank;
  logic                              s_match;
  logic                              s_better;

  // Update decisions
  logic [lfu_pkg::OCC_W-1:0]         cap_eff;
  logic                              cap_nz;
  logic                              is_put;
  logic                              commit;
  logic                              do_touch;
  logic                              do_data_wr;
  logic                              ins_path;
  logic                              do_evict;
  logic                              ins_have;
  logic [lfu_pkg::IDX_W-1:0]         ins_idx;
  logic                              do_insert;
  logic [lfu_pkg::COUNT_BITS-1:0]    hit_count;
  lfu_pkg::rsp_t                     rsp;

  assign in_stall  = (state != lfu_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Element under the scan pointer
  always_comb begin
    s_valid  = valid[idx];
    s_key    = key_mem[idx];
    s_count  = count_mem[idx];
    s_rank   = rank_mem[idx];
    s_match  = s_valid && (s_key == req.key);
    s_better = !vic_have || (s_count < vic_count) ||
               ((s_count == vic_count) && (s_rank > vic_rank));
  end

  // Decisions for the update cycle
  always_comb begin
    if (32'(capacity) > 32'(lfu_pkg::ENTRIES)) begin
      cap_eff = lfu_pkg::OCC_W'(lfu_pkg::ENTRIES);
    end else begin
      cap_eff = lfu_pkg::OCC_W'(capacity);
    end
    cap_nz     = (capacity != '0);
    is_put     = (req.func == lfu_pkg::FUNC_PUT);
    commit     = (state == lfu_pkg::ST_UPDATE) && !(out_valid && out_stall);
    do_touch   = hit_found && (!is_put || cap_nz);
    do_data_wr = hit_found && is_put && cap_nz;
    ins_path   = is_put && !hit_found && cap_nz;
    do_evict   = ins_path && (occ >= cap_eff) && vic_have;
    ins_have   = free_have || do_evict;
    if (do_evict && !(free_have && (free_idx < vic_idx))) begin
      ins_idx = vic_idx;
    end else begin
      ins_idx = free_idx;
    end
    do_insert  = ins_path && ins_have;
    hit_count  = count_mem[hit_idx];

    rsp.hit = hit_found;
    if (is_put) begin
      rsp.read_value = '0;
    end else if (hit_found) begin
      rsp.read_value = hit_data;
    end else begin
      rsp.read_value = '1;
    end
    rsp.evicted     = do_evict;
    rsp.evicted_key = do_evict ? vic_key : '0;
  end

  // Sequencer, capacity register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfu_pkg::ST_IDLE;
      out_valid <= 1'b0;
      capacity  <= lfu_pkg::CAP_W'(lfu_pkg::ENTRIES);
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        lfu_pkg::ST_IDLE: begin
          if (in_valid) begin
            state <= lfu_pkg::ST_SCAN;
          end
        end
        lfu_pkg::ST_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= lfu_pkg::ST_UPDATE;
          end
        end
        lfu_pkg::ST_UPDATE: begin
          if (commit) begin
            state     <= lfu_pkg::ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= lfu_pkg::ST_IDLE;
      endcase
    end
  end

  // Request capture, scan pointer, scan results and output data
  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= rsp;
    end
    if (state == lfu_pkg::ST_IDLE) begin
      req       <= in_data;
      idx       <= '0;
      hit_found <= 1'b0;
      vic_have  <= 1'b0;
      free_have <= 1'b0;
    end else if (state == lfu_pkg::ST_SCAN) begin
      idx <= idx + 1'b1;
      if (s_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
        hit_data  <= data_mem[idx];
        hit_rank  <= s_rank;
      end
      if (s_valid && s_better) begin
        vic_have  <= 1'b1;
        vic_idx   <= idx;
        vic_key   <= s_key;
        vic_count <= s_count;
        vic_rank  <= s_rank;
      end
      if (!s_valid && !free_have) begin
        free_have <= 1'b1;
        free_idx  <= idx;
      end
    end
  end

  // Valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (commit) begin
      if (do_evict) begin
        valid[vic_idx] <= 1'b0;
      end
      if (do_insert) begin
        valid[ins_idx] <= 1'b1;
      end
      occ <= occ - lfu_pkg::OCC_W'(do_evict) + lfu_pkg::OCC_W'(do_insert);
    end
  end

  // Entry payload and recency lanes
  always_ff @(posedge clk) begin
    if (commit) begin
      if (do_touch && (hit_count != COUNT_MAX)) begin
        count_mem[hit_idx] <= hit_count + 1'b1;
      end
      if (do_data_wr) begin
        data_mem[hit_idx] <= req.value;
      end
      if (do_insert) begin
        key_mem[ins_idx]   <= req.key;
        data_mem[ins_idx]  <= req.value;
        count_mem[ins_idx] <= lfu_pkg::COUNT_BITS'(1);
      end
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
        if (valid[i]) begin
          if (do_touch) begin
            if (lfu_pkg::IDX_W'(i) == hit_idx) begin
              rank_mem[i] <= '0;
            end else if (rank_mem[i] < hit_rank) begin
              rank_mem[i] <= rank_mem[i] + 1'b1;
            end
          end else if (do_insert) begin
            // insert: all ranks shift; when evicting, ranks above the victim close the gap first
            if (!do_evict) begin
              rank_mem[i] <= rank_mem[i] + 1'b1;
            end else if ((lfu_pkg::IDX_W'(i) != vic_idx) && (rank_mem[i] < vic_rank)) begin
              rank_mem[i] <= rank_mem[i] + 1'b1;
            end
          end
        end
      end
      if (do_insert) begin
        rank_mem[ins_idx] <= '0;
      end
    end
  end

  // Checks
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occ))
    else $error("occupancy differs from number of valid entries");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= 32'(lfu_pkg::ENTRIES))
    else $error("occupancy above table size");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.evicted && out_data.hit))
    else $error("eviction reported on a hit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !commit))
    else $error("sequencer not busy after a transaction");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("result not presented after update");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for lfu_cache_table: drives lookups and inserts, mirrors the table
// in a scoreboard class and checks every response in order.
// Depends on lfu_pkg and lfu_cache_table.
module testbench;

  // Mirror of the table: predicts each response and checks the block's output
  class lfu_mirror;
    logic [lfu_pkg::CAP_W-1:0]      capacity;
    bit                             used[lfu_pkg::ENTRIES];
    logic [lfu_pkg::WORD_W-1:0]     slot_key[lfu_pkg::ENTRIES];
    logic [lfu_pkg::WORD_W-1:0]     slot_data[lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0] slot_uses[lfu_pkg::ENTRIES];
    int unsigned                    slot_rank[lfu_pkg::ENTRIES];
    int unsigned                    filled;
    lfu_pkg::rsp_t                  expected_rsp_q[$];
    int                             errors;

    function new();
      capacity = lfu_pkg::CAP_W'(lfu_pkg::ENTRIES);
      filled   = 0;
      errors   = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_capacity(logic [lfu_pkg::CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Hit: bump the use count (saturating) and make slot most recent
    function void touch(int s);
      int unsigned old_rank;
      old_rank = slot_rank[s];
      if (slot_uses[s] != '1) slot_uses[s] = slot_uses[s] + 1'b1;
      for (int i = 0; i < lfu_pkg::ENTRIES; i++)
        if (used[i] && i != s && slot_rank[i] < old_rank) slot_rank[i] = slot_rank[i] + 1;
      slot_rank[s] = 0;
    endfunction

    // Apply one accepted transaction and queue the response it must produce
    function void note_request(lfu_pkg::req_t r);
      lfu_pkg::rsp_t e;
      int            found;
      int            victim;
      int            spot;
      int unsigned   lim;
      int unsigned   vr;
      lim    = (capacity > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : capacity;
      found  = -1;
      victim = -1;
      spot   = -1;
      e      = '0;
      for (int i = 0; i < lfu_pkg::ENTRIES; i++)
        if (found < 0 && used[i] && slot_key[i] == r.key) found = i;
      e.hit = (found >= 0);
      if (r.func == lfu_pkg::FUNC_GET) begin
        if (found >= 0) begin
          touch(found);
          e.read_value = slot_data[found];
        end else begin
          e.read_value = '1;
        end
      end else if (found >= 0) begin
        // overwrite in place; a disabled table leaves it untouched
        if (lim != 0) begin
          slot_data[found] = r.value;
          touch(found);
        end
      end else if (lim != 0) begin
        // full: drop lowest count, oldest among equals
        if (filled >= lim) begin
          for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_rank[i] > slot_rank[victim])))
              victim = i;
          if (victim >= 0) begin
            vr = slot_rank[victim];
            used[victim] = 1'b0;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
              if (used[i] && slot_rank[i] > vr) slot_rank[i] = slot_rank[i] - 1;
            filled--;
            e.evicted     = 1'b1;
            e.evicted_key = slot_key[victim];
          end
        end
        // new key goes to the lowest free slot
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
          if (spot < 0 && !used[i]) spot = i;
        if (spot >= 0) begin
          for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (used[i]) slot_rank[i] = slot_rank[i] + 1;
          used[spot]      = 1'b1;
          slot_key[spot]  = r.key;
          slot_data[spot] = r.value;
          slot_uses[spot] = lfu_pkg::COUNT_BITS'(1);
          slot_rank[spot] = 0;
          filled++;
        end
      end
      expected_rsp_q.push_back(e);
    endfunction

    function void check_response(lfu_pkg::rsp_t got);
      lfu_pkg::rsp_t e;
      if (expected_rsp_q.size() == 0) begin
        flag($sformatf("response with nothing outstanding: %h", got));
        return;
      end
      e = expected_rsp_q.pop_front();
      if (got.hit !== e.hit || got.read_value !== e.read_value ||
          got.evicted !== e.evicted || got.evicted_key !== e.evicted_key)
        flag($sformatf({"expected hit %b read_value %h evicted %b evicted_key %h, ",
                        "got hit %b read_value %h evicted %b evicted_key %h"},
                       e.hit, e.read_value, e.evicted, e.evicted_key,
                       got.hit, got.read_value, got.evicted, got.evicted_key));
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  lfu_pkg::req_t             in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  lfu_pkg::rsp_t             out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [lfu_pkg::CAP_W-1:0] cfg_data  = '0;

  lfu_mirror                  mirror;
  logic [lfu_pkg::WORD_W-1:0] key_pool[32];
  bit                         quiet        = 1'b0;
  int unsigned                hold_request = 0;
  int unsigned                hold_left    = 0;

  lfu_cache_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Response side: check accepted transactions, random stalls, long hold-off
  always @(posedge clk) begin
    if (out_valid && !out_stall) mirror.check_response(out_data);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 37);
    end
  end

  function automatic lfu_pkg::req_t build_request(lfu_pkg::func_t f,
                                                  logic [lfu_pkg::WORD_W-1:0] k,
                                                  logic [lfu_pkg::WORD_W-1:0] v);
    lfu_pkg::req_t r;
    r.func  = f;
    r.key   = k;
    r.value = v;
    return r;
  endfunction

  // Mostly keys from a small pool so hits and evictions are frequent
  function automatic lfu_pkg::req_t random_request(int span);
    lfu_pkg::req_t r;
    r.func = $urandom_range(1) ? lfu_pkg::FUNC_PUT : lfu_pkg::FUNC_GET;
    r.key  = ($urandom_range(99) < 15) ? $urandom : key_pool[$urandom_range(span - 1)];
    case ($urandom_range(9))
      0:       r.value = {1'b1, {31{1'b0}}};
      1:       r.value = {1'b0, {31{1'b1}}};
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_item(input lfu_pkg::req_t r);
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_request(r);
  endtask

  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mirror.set_capacity(c);
  endtask

  // Stop offering and wait for every response, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic run_phase(input logic [lfu_pkg::CAP_W-1:0] cap, input int n,
                           input int span, input bit calm, input int hold_at,
                           input int drain_at);
    settle();
    write_capacity(cap);
    quiet = calm;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_request = 220;
      if (i == drain_at) settle();
      send_item(random_request(span));
    end
    quiet = 1'b0;
  endtask

  initial begin
    mirror      = new();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two-entry table: miss, inserts, hit, LFU eviction, overwrite, LRU tie break
    write_capacity(5'd2);
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0));
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h8000_0000, 32'h0));
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h0000_0000, 32'h5555_5555));
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h8000_0000, 32'h0));

    // Disabled table: puts change nothing, stored entries still readable
    settle();
    write_capacity(5'd0);
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0005));
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0001));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h0000_0000, 32'h0));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h0000_0005, 32'h0));

    // Fill to three, then shrink capacity below occupancy
    settle();
    write_capacity(5'd3);
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h0000_0001, 32'hAAAA_AAAA));
    settle();
    write_capacity(5'd1);
    send_item(build_request(lfu_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0002));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'h0000_0002, 32'h0));
    send_item(build_request(lfu_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0));

    // Random phases over several capacities
    run_phase(5'd16, 70, 24, 1'b0, -1, -1);
    run_phase(5'd3,  60, 8,  1'b0, 15, -1);
    run_phase(5'd0,  30, 8,  1'b0, -1, -1);
    run_phase(5'd31, 70, 24, 1'b1, -1, -1);
    run_phase(5'd1,  50, 4,  1'b0, -1, -1);
    run_phase(5'd8,  70, 12, 1'b0, -1, 35);
    run_phase(5'd17, 60, 20, 1'b0, -1, -1);
    run_phase(lfu_pkg::CAP_W'($urandom_range(31)), 90, 20, 1'b0, -1, -1);

    settle();
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("lfu_cache_table test passed");
    end else begin
      $display("lfu_cache_table test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("lfu_cache_table test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lfu_pkg.sv
rtl/lfu_cache_table.sv
bench/testbench.sv
